@@ rtl/ui_hit_test_focus_controller_defines.svh @@
// Assertion macros for the verification files of the hit-test focus controller.
// A user of these macros provides clk and rst signals in its own scope.
`ifndef UI_HIT_TEST_FOCUS_CONTROLLER_DEFINES_SVH
`define UI_HIT_TEST_FOCUS_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UHTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UHTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/uhtf_pkg.sv @@
// Shared types and constants of the hit-test focus controller.
// No dependencies; every other file but the assertion macros header imports this package.
package uhtf_pkg;

  localparam int CMD_W      = 4;
  localparam int ID_W       = 8;
  localparam int COORD_W    = 16;
  localparam int DIM_W      = 15;
  localparam int SLOT_OUT_W = 5;

  // Encoding of "no slot" on the result fields.
  localparam logic [SLOT_OUT_W-1:0] SLOT_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_DEFINE      = 4'd0,
    CMD_ENABLE      = 4'd1,
    CMD_FOCUS       = 4'd2,
    CMD_PREVIOUS    = 4'd3,
    CMD_NEXT        = 4'd4,
    CMD_ACTIVATE    = 4'd5,
    CMD_MOVE        = 4'd6,
    CMD_DOWN        = 4'd7,
    CMD_UP          = 4'd8,
    CMD_TAKE        = 4'd9,
    CMD_CLEAR_DIRTY = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STEP,
    ST_COMMIT
  } state_t;

  // One slot rectangle as held in the bounds memory.
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [DIM_W-1:0]          w;
    logic [DIM_W-1:0]          h;
  } bounds_t;

endpackage

@@ rtl/uhtf_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on uhtf_pkg for field widths.
interface uhtf_in_if import uhtf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [ID_W-1:0]           slot_id;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [DIM_W-1:0]          rect_width;
  logic [DIM_W-1:0]          rect_height;
  logic                      enable_flag;

  modport source (output valid, cmd, slot_id, coord_x, coord_y, rect_width, rect_height,
                  enable_flag, input ready);
  modport sink (input valid, cmd, slot_id, coord_x, coord_y, rect_width, rect_height,
                enable_flag, output ready);
endinterface

interface uhtf_out_if import uhtf_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic signed [SLOT_OUT_W-1:0] result_slot;
  logic                         taken;
  logic signed [SLOT_OUT_W-1:0] focused_slot;
  logic signed [SLOT_OUT_W-1:0] captured_slot;
  logic                         dragging;
  logic                         needs_frame;

  modport source (output valid, status, result_slot, taken, focused_slot, captured_slot,
                  dragging, needs_frame, input ready);
  modport sink (input valid, status, result_slot, taken, focused_slot, captured_slot,
                dragging, needs_frame, output ready);
endinterface

@@ rtl/ui_hit_test_focus_controller.sv @@
// Pointer move/down/up: one bounds memory read and one containment test per slot, then
// a drain state before commit. Previous/next: one candidate slot per cycle until a usable
// slot is found or all are tried. All other commands go from idle straight to commit.
// A new item is accepted only in the idle state, the cycle after the result is registered,
// so no new item is taken before the last result is registered; a stalled result holds commit.
// Synchronous reset clears all slot marks, focus, capture, activation and flags.
module ui_hit_test_focus_controller import uhtf_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input logic       clk,
  input logic       rst,
  uhtf_in_if.sink   in_ch,
  uhtf_out_if.source out_ch
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t state, state_next;

  // Latched command item.
  cmd_t                      cmd_q;
  logic [ID_W-1:0]           id_q;
  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic [DIM_W-1:0]          w_q;
  logic [DIM_W-1:0]          h_q;
  logic                      en_q;

  // Sequencer counter and focus-step candidate.
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cand;
  logic             found;
  logic [IDX_W-1:0] step_idx;

  // Slot marks and tracked indices.
  logic [NUM_SLOTS-1:0] init_bits, init_bits_next;
  logic [NUM_SLOTS-1:0] en_bits, en_bits_next;
  logic             focus_vld, focus_vld_next;
  logic [IDX_W-1:0] focus_idx, focus_idx_next;
  logic             cap_vld, cap_vld_next;
  logic [IDX_W-1:0] cap_idx, cap_idx_next;
  logic             act_vld, act_vld_next;
  logic [IDX_W-1:0] act_idx, act_idx_next;
  logic             drag, drag_next;
  logic             dirty, dirty_next;

  // Scan pipeline and hit result.
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_use;
  logic             hit_vld;
  logic [IDX_W-1:0] hit_idx;
  logic             cmp_hit;
  bounds_t          rd_data;
  bounds_t          wr_data;
  logic             wr_en;

  // Output register.
  logic                  out_valid;
  logic                  res_status, res_status_next;
  logic [SLOT_OUT_W-1:0] res_slot, res_slot_next;
  logic                  res_taken, res_taken_next;
  logic [SLOT_OUT_W-1:0] res_focus, res_cap;
  logic                  res_drag, res_dirty;

  logic             in_acc;
  logic             commit;
  logic             id_ok;
  logic [IDX_W-1:0] id_idx;
  logic             dim_ok;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign commit      = (state == ST_COMMIT) && (!out_valid || out_ch.ready);
  assign id_ok       = id_q < ID_W'(NUM_SLOTS);
  assign id_idx      = id_q[IDX_W-1:0];
  assign dim_ok      = (w_q != '0) && (h_q != '0);

  // Bounds storage and the shared containment test.
  assign wr_en   = commit && (cmd_q == CMD_DEFINE) && id_ok && dim_ok;
  assign wr_data = '{left: x_q, top: y_q, w: w_q, h: h_q};

  uhtf_bounds_mem #(.DEPTH(NUM_SLOTS), .AW(IDX_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (id_idx),
    .wr_data (wr_data),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  uhtf_hit_unit u_hit (
    .bounds (rd_data),
    .px     (x_q),
    .py     (y_q),
    .hit    (cmp_hit)
  );

  // Wrapping neighbor of the current focus-step candidate.
  always_comb begin
    if (cmd_q == CMD_NEXT) begin
      step_idx = (cand == LAST_IDX) ? '0 : cand + 1'b1;
    end else begin
      step_idx = (cand == '0) ? LAST_IDX : cand - 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_ch.cmd)) inside
            CMD_MOVE, CMD_DOWN, CMD_UP: state_next = ST_SCAN;
            CMD_PREVIOUS, CMD_NEXT:     state_next = ST_STEP;
            default:                    state_next = ST_COMMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_STEP: begin
        if ((init_bits[step_idx] && en_bits[step_idx]) || cnt == LAST_IDX) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Effect of the finished command on the slot state and the result.
  always_comb begin
    init_bits_next  = init_bits;
    en_bits_next    = en_bits;
    focus_vld_next  = focus_vld;
    focus_idx_next  = focus_idx;
    cap_vld_next    = cap_vld;
    cap_idx_next    = cap_idx;
    act_vld_next    = act_vld;
    act_idx_next    = act_idx;
    drag_next       = drag;
    dirty_next      = dirty;
    res_status_next = 1'b0;
    res_slot_next   = SLOT_NONE;
    res_taken_next  = 1'b0;
    case (cmd_q)
      CMD_DEFINE: begin
        if (!id_ok || !dim_ok) begin
          res_status_next = 1'b1;
        end else if (!init_bits[id_idx]) begin
          init_bits_next[id_idx] = 1'b1;
          en_bits_next[id_idx]   = 1'b1;
        end
      end
      CMD_ENABLE: begin
        if (!id_ok || !init_bits[id_idx]) begin
          res_status_next = 1'b1;
        end else if (en_bits[id_idx] != en_q) begin
          en_bits_next[id_idx] = en_q;
          dirty_next           = 1'b1;
          if (!en_q && focus_vld && focus_idx == id_idx) begin
            focus_vld_next = 1'b0;
          end
          if (!en_q && cap_vld && cap_idx == id_idx) begin
            cap_vld_next = 1'b0;
            drag_next    = 1'b0;
          end
        end
      end
      CMD_FOCUS: begin
        if (!id_ok || !init_bits[id_idx] || !en_bits[id_idx]) begin
          res_status_next = 1'b1;
        end else begin
          focus_vld_next = 1'b1;
          focus_idx_next = id_idx;
          dirty_next     = 1'b1;
        end
      end
      CMD_PREVIOUS, CMD_NEXT: begin
        dirty_next = 1'b1;
        if (found) begin
          focus_vld_next = 1'b1;
          focus_idx_next = cand;
        end
      end
      CMD_ACTIVATE: begin
        dirty_next    = 1'b1;
        act_vld_next  = focus_vld;
        act_idx_next  = focus_idx;
        res_slot_next = focus_vld ? SLOT_OUT_W'(focus_idx) : SLOT_NONE;
      end
      CMD_MOVE: begin
        dirty_next = 1'b1;
      end
      CMD_DOWN: begin
        dirty_next   = 1'b1;
        cap_vld_next = hit_vld;
        cap_idx_next = hit_idx;
        drag_next    = hit_vld;
        if (hit_vld) begin
          focus_vld_next = 1'b1;
          focus_idx_next = hit_idx;
        end
      end
      CMD_UP: begin
        dirty_next   = 1'b1;
        cap_vld_next = 1'b0;
        drag_next    = 1'b0;
        if (cap_vld && hit_vld && cap_idx == hit_idx) begin
          act_vld_next = 1'b1;
          act_idx_next = hit_idx;
        end
        res_slot_next = act_vld_next ? SLOT_OUT_W'(act_idx_next) : SLOT_NONE;
      end
      CMD_TAKE: begin
        if (!id_ok) begin
          res_status_next = 1'b1;
        end else if (act_vld && act_idx == id_idx) begin
          act_vld_next   = 1'b0;
          res_taken_next = 1'b1;
        end
      end
      CMD_CLEAR_DIRTY: begin
        dirty_next = 1'b0;
      end
      default: begin
        res_status_next = 1'b1;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item latch, counter and focus-step candidate.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q <= cmd_t'(in_ch.cmd);
      id_q  <= in_ch.slot_id;
      x_q   <= in_ch.coord_x;
      y_q   <= in_ch.coord_y;
      w_q   <= in_ch.rect_width;
      h_q   <= in_ch.rect_height;
      en_q  <= in_ch.enable_flag;
      cnt   <= '0;
      cand  <= focus_vld ? focus_idx : LAST_IDX;
      found <= 1'b0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end else if (state == ST_STEP) begin
      cand <= step_idx;
      cnt  <= cnt + 1'b1;
      if (init_bits[step_idx] && en_bits[step_idx]) begin
        found <= 1'b1;
      end
    end
  end

  // Scan pipeline: one slot read per cycle, compared when its data returns.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      hit_vld <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      if (in_acc) begin
        hit_vld <= 1'b0;
      end else if (rd_pend && rd_use && cmp_hit) begin
        hit_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    rd_use <= init_bits[cnt] && en_bits[cnt];
    if (rd_pend && rd_use && cmp_hit) begin
      hit_idx <= rd_idx;
    end
  end

  // Slot marks and tracked indices, updated when a command completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_bits <= '0;
      en_bits   <= '0;
      focus_vld <= 1'b0;
      focus_idx <= '0;
      cap_vld   <= 1'b0;
      cap_idx   <= '0;
      act_vld   <= 1'b0;
      act_idx   <= '0;
      drag      <= 1'b0;
      dirty     <= 1'b0;
    end else if (commit) begin
      init_bits <= init_bits_next;
      en_bits   <= en_bits_next;
      focus_vld <= focus_vld_next;
      focus_idx <= focus_idx_next;
      cap_vld   <= cap_vld_next;
      cap_idx   <= cap_idx_next;
      act_vld   <= act_vld_next;
      act_idx   <= act_idx_next;
      drag      <= drag_next;
      dirty     <= dirty_next;
    end
  end

  // Output register holds the result item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_taken  <= res_taken_next;
      res_focus  <= focus_vld_next ? SLOT_OUT_W'(focus_idx_next) : SLOT_NONE;
      res_cap    <= cap_vld_next ? SLOT_OUT_W'(cap_idx_next) : SLOT_NONE;
      res_drag   <= drag_next;
      res_dirty  <= dirty_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = res_status;
  assign out_ch.result_slot   = res_slot;
  assign out_ch.taken         = res_taken;
  assign out_ch.focused_slot  = res_focus;
  assign out_ch.captured_slot = res_cap;
  assign out_ch.dragging      = res_drag;
  assign out_ch.needs_frame   = res_dirty;

endmodule

@@ rtl/uhtf_bounds_mem.sv @@
// Slot bounds memory: one write port, one read port with registered read data.
// Depends on uhtf_pkg for the bounds_t entry type.
module uhtf_bounds_mem import uhtf_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  bounds_t       wr_data,
  input  logic [AW-1:0] rd_addr,
  output bounds_t       rd_data
);

  bounds_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/uhtf_hit_unit.sv @@
// Shared rectangle containment test used once per scanned slot.
// Depends on uhtf_pkg for the bounds_t type.
module uhtf_hit_unit import uhtf_pkg::*; (
  input  bounds_t                   bounds,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  output logic                      hit
);

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;

  // Offsets from the top-left corner; the point is inside when both are
  // non-negative and below the size.
  always_comb begin
    dx  = {px[COORD_W-1], px} - {bounds.left[COORD_W-1], bounds.left};
    dy  = {py[COORD_W-1], py} - {bounds.top[COORD_W-1], bounds.top};
    hit = !dx[COORD_W] && !dy[COORD_W] &&
          (dx[COORD_W-1:0] < COORD_W'(bounds.w)) &&
          (dy[COORD_W-1:0] < COORD_W'(bounds.h));
  end

endmodule

@@ rtl/uhtf_checker.sv @@
// Port-level checks of the hit-test focus controller, bound to the top level.
// Depends on uhtf_pkg and the assertion macros header.
`include "ui_hit_test_focus_controller_defines.svh"

module uhtf_checker import uhtf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  status,
  input logic                  taken,
  input logic [SLOT_OUT_W-1:0] result_slot
);

  // A stalled result item keeps its contents.
  `UHTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_slot) && $stable(taken), "result item changed while stalled")

  // One item at a time: accepting an item closes the input.
  `UHTF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input still ready after an accepted item")

  // An argument error never reports an activation or a take.
  `UHTF_ASSERT_NOW(a_err_clean, out_valid && status, result_slot == SLOT_NONE && !taken, "error item carries a result")

  // A successful take comes only from the take command, which returns no slot.
  `UHTF_ASSERT_NOW(a_take_clean, out_valid && taken, !status && result_slot == SLOT_NONE, "taken item carries a slot or an error")

endmodule

bind ui_hit_test_focus_controller uhtf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .taken       (out_ch.taken),
  .result_slot (out_ch.result_slot)
);
